// ===== design/wcf_pkg.sv =====
// Shared constants, codes and control structs for the weighted capacity FIFO.
// Used by the controller, the datapath and the top level; depends on nothing.
package wcf_pkg;

  // Number of entries the queue can hold.
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IdxW    = $clog2(DEPTH);
  localparam int unsigned CntW    = $clog2(DEPTH + 1);
  localparam int unsigned WordW   = 32;
  localparam int unsigned WeightW = 16;
  // Wide enough for DEPTH entries of the largest weight, so the total never wraps.
  localparam int unsigned TotW    = $clog2(DEPTH * ((1 << WeightW) - 1) + 1);
  localparam int unsigned KindW   = 3;
  localparam int unsigned StatusW = 2;

  localparam int unsigned InDataW  = 3 * WordW + WeightW;
  localparam int unsigned OutDataW = 3 * WordW + WeightW + CntW + 1 + 1 + WeightW + 1;

  localparam logic [IdxW-1:0]    LAST_IDX       = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0]    DEPTH_CNT      = CntW'(DEPTH);
  localparam logic [WeightW-1:0] UNLIMITED_ROOM = '1;

  // Operation kinds carried in the input tuser.
  localparam logic [KindW-1:0] KIND_TRY_PUT = 3'd0;
  localparam logic [KindW-1:0] KIND_TRY_GET = 3'd1;
  localparam logic [KindW-1:0] KIND_CLOSE   = 3'd2;
  localparam logic [KindW-1:0] KIND_CA_PUT  = 3'd3;
  localparam logic [KindW-1:0] KIND_CA_GET  = 3'd4;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [StatusW-1:0] ST_BUSY      = 2'd2;
  localparam logic [StatusW-1:0] ST_CLOSED    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // register the incoming transaction
    logic read_head;  // read the head entry into the read register
    logic exec;       // decide the status and update the queue state
    logic load_out;   // load the result register
  } wcf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // result register is empty or being taken this cycle
  } wcf_sts_t;

endpackage

// ===== design/wcf_ctrl.sv =====
// Sequencer of the weighted capacity FIFO: accept, head read, execute, respond.
// Depends on wcf_pkg for the command and status structs.
module wcf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wcf_pkg::wcf_sts_t sts_i,
  output wcf_pkg::wcf_cmd_t cmd_o
);
  import wcf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_READ;
            ready_q <= 1'b0;
          end
        end
        S_READ: state_q <= S_EXEC;
        S_EXEC: state_q <= S_RESP;
        S_RESP: begin
          // Hold here until the previous result has left the output register.
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = ready_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = ready_q && in_valid_i;
    cmd_o.read_head = (state_q == S_READ);
    cmd_o.exec      = (state_q == S_EXEC);
    cmd_o.load_out  = (state_q == S_RESP) && sts_i.out_free;
  end

endmodule

// ===== design/wcf_dp.sv =====
// Datapath of the weighted capacity FIFO: entry memory, pointers, weight total,
// status decision and result register. Depends on wcf_pkg.
module wcf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wcf_pkg::wcf_cmd_t                 cmd_i,
  output wcf_pkg::wcf_sts_t                 sts_o,
  input  logic [wcf_pkg::InDataW-1:0]       in_data_i,
  input  logic [wcf_pkg::KindW-1:0]         in_kind_i,
  input  logic                              cfg_valid_i,
  input  logic [wcf_pkg::WeightW-1:0]       cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [wcf_pkg::OutDataW-1:0]      out_data_o,
  output logic [wcf_pkg::StatusW-1:0]       out_status_o
);
  import wcf_pkg::*;

  // Captured transaction.
  logic [KindW-1:0]   kind_q;
  logic [WordW-1:0]   id_q, op_q, handle_q;
  logic [WeightW-1:0] weight_q;

  // Entry memory and its registered read port.
  logic [WordW-1:0]   mem_id     [DEPTH];
  logic [WordW-1:0]   mem_op     [DEPTH];
  logic [WordW-1:0]   mem_handle [DEPTH];
  logic [WeightW-1:0] mem_weight [DEPTH];
  logic [WordW-1:0]   rd_id_q, rd_op_q, rd_handle_q;
  logic [WeightW-1:0] rd_weight_q;

  // Queue state.
  logic [IdxW-1:0]    head_q, tail_q;
  logic [CntW-1:0]    count_q;
  logic [TotW-1:0]    total_q;
  logic               closed_q;
  logic [WeightW-1:0] limit_q;

  // Per-transaction outcome.
  logic [StatusW-1:0] status_q, status_d;
  logic               get_ok_q;
  logic               put_ok, get_ok;

  // Result register.
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [StatusW-1:0]  out_status_q;

  logic            limit_nz, too_large, no_room, at_depth, is_empty;
  logic [TotW:0]   sum_w;
  logic            full_now;
  logic [WeightW-1:0] room_now;
  logic [TotW-1:0]    limit_ext;
  logic [IdxW-1:0]    head_next, tail_next;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= in_kind_i;
      id_q     <= in_data_i[WordW-1:0];
      op_q     <= in_data_i[2*WordW-1:WordW];
      handle_q <= in_data_i[3*WordW-1:2*WordW];
      weight_q <= in_data_i[3*WordW+WeightW-1:3*WordW];
    end
  end

  assign limit_nz  = (limit_q != '0);
  assign limit_ext = TotW'(limit_q);
  assign too_large = (weight_q > limit_q);
  assign sum_w     = {1'b0, total_q} + (TotW + 1)'(weight_q);
  assign no_room   = (sum_w > {1'b0, limit_ext});
  assign at_depth  = (count_q == DEPTH_CNT);
  assign is_empty  = (count_q == '0);
  assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;

  always_comb begin
    status_d = ST_OK;
    put_ok   = 1'b0;
    get_ok   = 1'b0;
    case (kind_q)
      KIND_TRY_PUT, KIND_CA_PUT: begin
        if (limit_nz && too_large) begin
          status_d = ST_TOO_LARGE;
        end else if (limit_nz && (kind_q == KIND_CA_PUT) && closed_q) begin
          status_d = ST_CLOSED;
        end else if ((limit_nz && no_room) || at_depth) begin
          status_d = ST_BUSY;
        end else begin
          put_ok = 1'b1;
        end
      end
      KIND_TRY_GET, KIND_CA_GET: begin
        if ((kind_q == KIND_CA_GET) && closed_q) begin
          status_d = ST_CLOSED;
        end else if (is_empty) begin
          status_d = ST_BUSY;
        end else begin
          get_ok = 1'b1;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  // Memory write at the tail and registered read at the head.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && put_ok) begin
      mem_id[tail_q]     <= id_q;
      mem_op[tail_q]     <= op_q;
      mem_handle[tail_q] <= handle_q;
      mem_weight[tail_q] <= weight_q;
    end
    if (cmd_i.read_head) begin
      rd_id_q     <= mem_id[head_q];
      rd_op_q     <= mem_op[head_q];
      rd_handle_q <= mem_handle[head_q];
      rd_weight_q <= mem_weight[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      total_q  <= '0;
      closed_q <= 1'b0;
      limit_q  <= '0;
      status_q <= ST_OK;
      get_ok_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        status_q <= status_d;
        get_ok_q <= get_ok;
        if (put_ok) begin
          tail_q  <= tail_next;
          count_q <= count_q + 1'b1;
          total_q <= sum_w[TotW-1:0];
        end
        if (get_ok) begin
          head_q  <= head_next;
          count_q <= count_q - 1'b1;
          total_q <= total_q - TotW'(rd_weight_q);
        end
        if (kind_q == KIND_CLOSE) begin
          closed_q <= 1'b1;
        end
      end
    end
  end

  // Queue condition after the transaction, taken from the updated state.
  assign full_now = limit_nz && (total_q >= limit_ext);
  always_comb begin
    if (!limit_nz) begin
      room_now = UNLIMITED_ROOM;
    end else if (full_now) begin
      room_now = '0;
    end else begin
      room_now = WeightW'(limit_ext - total_q);
    end
  end

  always_comb begin
    out_data_d = {closed_q, room_now, full_now, is_empty, count_q,
                  get_ok_q ? rd_weight_q : '0,
                  get_ok_q ? rd_handle_q : '0,
                  get_ok_q ? rd_op_q     : '0,
                  get_ok_q ? rd_id_q     : '0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q   <= out_data_d;
      out_status_q <= status_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_status_o   = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("entry count exceeds the depth");

  a_empty_no_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (total_q == '0))
    else $error("empty queue holds a nonzero weight total");

  a_put_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && put_ok) |=> (count_q == $past(count_q) + 1'b1))
    else $error("accepted put did not add one entry");

  a_get_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && get_ok) |=> (count_q == $past(count_q) - 1'b1))
    else $error("successful get did not remove one entry");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("result load did not raise the output valid");

endmodule

// ===== design/weighted_capacity_fifo.sv =====
// Top level of the weighted capacity FIFO: stream ports and configuration port.
// Depends on wcf_pkg, wcf_ctrl and wcf_dp.
//
// A queue of up to 16 job entries whose capacity is the summed entry weight
// against weight_limit (zero means unlimited). Each input transaction (put,
// get, close, or a close-aware put or get) yields exactly one result
// transaction with a status and the queue condition after the operation.
// After the accepting edge the controller steps through a registered read of
// the head entry, execute and result load; the result becomes valid and the
// input is ready again in the same cycle, so a new transaction is accepted
// only after the previous result has been loaded into the output register.
// The result sits in that output register, so the next transaction is
// accepted while it waits; if it has not been taken when the next result is
// ready, the block holds in its response step. Write weight_limit only while
// no transaction is in flight.
module weighted_capacity_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // job_id [31:0], job_op [63:32], payload_handle [95:64], weight [111:96]
  input  logic [wcf_pkg::InDataW-1:0]       s_axis_tdata_i,
  // kind [2:0]
  input  logic [wcf_pkg::KindW-1:0]         s_axis_tuser_i,
  // Result stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // got_id [31:0], got_op [63:32], got_handle [95:64], got_weight [111:96],
  // entry_count [116:112], is_empty [117], is_full [118], room_left [134:119],
  // is_closed [135]
  output logic [wcf_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // status [1:0]
  output logic [wcf_pkg::StatusW-1:0]       m_axis_tuser_o,
  // Configuration write channel: weight_limit.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wcf_pkg::WeightW-1:0]       cfg_data_i
);
  import wcf_pkg::*;

  wcf_cmd_t cmd;
  wcf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  wcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wcf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_data_i    (s_axis_tdata_i),
    .in_kind_i    (s_axis_tuser_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_data_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

endmodule
